FILE: rtl/core/cht_pkg.sv
// Shared constants and types for the chained hash table.
package cht_pkg;

  // Table geometry.
  localparam int BUCKETS     = 1024;
  localparam int CHAIN_DEPTH = 16;

  // Field widths.
  localparam int KEY_W    = 31;
  localparam int MOD_W    = 11;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Derived widths.
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int IDX_W    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int LEN_W    = $clog2(CHAIN_DEPTH + 1);
  localparam int ADDR_W   = BUCKET_W + IDX_W;
  localparam int KEYS_DEPTH = BUCKETS * CHAIN_DEPTH;

  // Divider: two quotient bits per cycle over the zero-extended key.
  localparam int DIVIDEND_W = KEY_W + (KEY_W % 2);
  localparam int DIV_STEPS  = DIVIDEND_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1009);

  // Request opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // Top-level sequencer states.
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DIV    = 6'b000100,
    S_LWAIT  = 6'b001000,
    S_LEN    = 6'b010000,
    S_SCAN   = 6'b100000
  } state_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/cht_mod_unit.sv
// Iterative remainder unit: key mod divisor, two bits per cycle.
module cht_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cht_pkg::KEY_W-1:0]    dividend,
  input  logic [cht_pkg::MOD_W-1:0]    divisor,
  output cht_pkg::div_stat_t           stat,
  output logic [cht_pkg::MOD_W-1:0]    remainder
);

  logic [cht_pkg::DIVIDEND_W-1:0] q_r, q_nxt;
  logic [cht_pkg::MOD_W-1:0]      r_r, r_nxt;
  logic [cht_pkg::MOD_W-1:0]      m_r, m_nxt;
  logic [cht_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [cht_pkg::MOD_W-1:0]      r_mid;

  // One restoring step: shift in a bit, subtract the divisor if it fits.
  function automatic logic [cht_pkg::MOD_W-1:0] rem_step(
    input logic [cht_pkg::MOD_W-1:0] r,
    input logic                      b,
    input logic [cht_pkg::MOD_W-1:0] m
  );
    logic [cht_pkg::MOD_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[cht_pkg::MOD_W-1:0];
  endfunction

  // Next-state logic for the shift and remainder registers.
  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    r_mid    = rem_step(r_r, q_r[cht_pkg::DIVIDEND_W-1], m_r);
    if (start) begin
      q_nxt    = cht_pkg::DIVIDEND_W'(dividend);
      r_nxt    = '0;
      m_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = rem_step(r_mid, q_r[cht_pkg::DIVIDEND_W-2], m_r);
      q_nxt   = {q_r[cht_pkg::DIVIDEND_W-3:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cht_pkg::DIV_CNT_W'(cht_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    m_r <= m_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = r_r;

endmodule

FILE: rtl/core/chained_hash_table.sv
// Top level of the chained hash table: sequencer, chain memories and ports.
//
// Requests arrive on the in_ stream: opcode 0 inserts the key, opcode 1
// searches for it. Each request yields exactly one result on the out_ stream
// with a status and a compare count. The bucket is the key modulo the
// register written on the cfg_ channel (zero acts as one, values above the
// bucket count act as the bucket count); write it only while no request is
// in flight.
// One request is handled at a time. The remainder unit runs first, the bucket
// is then registered, and the chain length memory is read through the S_LWAIT
// and S_LEN states. The chain of L keys (0 to 16) then streams through the
// registered-read key memory with each compare in the cycle after its read,
// and the result is written back once the output register is free.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits; a stalled receiver holds a finished
// result back only until the output register frees.
// After reset the chain length memory is cleared one entry per cycle, every
// bucket in turn; in_tready stays low during that pass while cfg_ writes are
// taken as usual.
module chained_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: modulus.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  // Requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [0] opcode, [31:1] key
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [2:0] status, [7:3] compare_count
);

  localparam int KW = cht_pkg::KEY_W;
  localparam int LW = cht_pkg::LEN_W;
  localparam int BW = cht_pkg::BUCKET_W;
  localparam int IW = cht_pkg::IDX_W;

  cht_pkg::state_t state_r, state_nxt;

  logic [cht_pkg::MOD_W-1:0] modulus_r, modulus_nxt;
  logic [cht_pkg::MOD_W-1:0] mod_eff;
  logic                      in_acc;

  logic          op_r, op_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [BW-1:0] bucket_r, bucket_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] issue_r, issue_nxt;
  logic [LW-1:0] pidx_r, pidx_nxt;
  logic          pend_r, pend_nxt;
  logic          found_r, found_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [BW-1:0] clr_r, clr_nxt;
  logic          fin_r, fin_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [cht_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [cht_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  cht_pkg::div_stat_t        div_stat;
  logic [cht_pkg::MOD_W-1:0] div_rem;

  // Chain memories.
  logic [KW-1:0] key_mem [cht_pkg::KEYS_DEPTH];
  logic [LW-1:0] len_mem [cht_pkg::BUCKETS];
  logic [KW-1:0] key_q;
  logic [LW-1:0] len_q;
  logic [cht_pkg::ADDR_W-1:0] key_ra, key_wa;
  logic          key_we, len_we;
  logic [BW-1:0] len_wa;
  logic [LW-1:0] len_wd;

  logic          issuing;
  logic          load_out;
  logic [LW:0]   len_plus;
  logic          chain_full;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == cht_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Effective divisor: zero acts as one, saturate at the bucket count.
  always_comb begin
    mod_eff = modulus_r;
    if (modulus_r == '0) begin
      mod_eff = cht_pkg::MOD_W'(1);
    end else if ({1'b0, modulus_r} > (cht_pkg::MOD_W + 1)'(cht_pkg::BUCKETS)) begin
      mod_eff = cht_pkg::MOD_W'(cht_pkg::BUCKETS);
    end
  end

  cht_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .dividend  (in_tdata[31:1]),
    .divisor   (mod_eff),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  assign len_plus   = {1'b0, len_r} + 1'b1;
  assign chain_full = (len_r >= LW'(cht_pkg::CHAIN_DEPTH));
  assign issuing    = (state_r == cht_pkg::S_SCAN) && (issue_r < len_r);
  assign load_out   = fin_r && (!out_valid_r || out_tready);
  assign key_ra     = {bucket_r, issue_r[IW-1:0]};
  assign key_wa     = {bucket_r, len_r[IW-1:0]};

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    modulus_nxt    = modulus_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    bucket_nxt     = bucket_r;
    len_nxt        = len_r;
    issue_nxt      = issue_r;
    pidx_nxt       = pidx_r;
    pend_nxt       = 1'b0;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    clr_nxt        = clr_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    key_we         = 1'b0;
    len_we         = 1'b0;
    len_wa         = bucket_r;
    len_wd         = len_plus[LW-1:0];

    if (cfg_valid && cfg_ready) begin
      modulus_nxt = cfg_data;
    end

    case (state_r)
      cht_pkg::S_CLEAR: begin
        len_we  = 1'b1;
        len_wa  = clr_r;
        len_wd  = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BW'(cht_pkg::BUCKETS - 1)) begin
          state_nxt = cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tdata[0];
          key_nxt   = in_tdata[31:1];
          state_nxt = cht_pkg::S_DIV;
        end
      end
      cht_pkg::S_DIV: begin
        if (div_stat.done) begin
          bucket_nxt = div_rem[BW-1:0];
          state_nxt  = cht_pkg::S_LWAIT;
        end
      end
      cht_pkg::S_LWAIT: begin
        state_nxt = cht_pkg::S_LEN;
      end
      cht_pkg::S_LEN: begin
        len_nxt   = (len_q > LW'(cht_pkg::CHAIN_DEPTH)) ? LW'(cht_pkg::CHAIN_DEPTH) : len_q;
        issue_nxt = '0;
        found_nxt = 1'b0;
        state_nxt = cht_pkg::S_SCAN;
      end
      cht_pkg::S_SCAN: begin
        // Reads are issued back to back; data is compared in the following cycle.
        if (issuing) begin
          issue_nxt = issue_r + 1'b1;
          pidx_nxt  = issue_r;
          pend_nxt  = 1'b1;
        end
        if (pend_r && (key_q == key_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = pidx_r + 1'b1;
          pend_nxt  = 1'b0;
          fin_nxt   = 1'b1;
          state_nxt = cht_pkg::S_IDLE;
        end else if (!issuing && !pend_r) begin
          fin_nxt   = 1'b1;
          state_nxt = cht_pkg::S_IDLE;
        end
        // The idle state must not take a request until the result is out.
        if (state_nxt == cht_pkg::S_IDLE) begin
          state_nxt = cht_pkg::S_SCAN;
        end
      end
      default: begin
        state_nxt = cht_pkg::S_CLEAR;
      end
    endcase

    // Result settle and write-back, held while the output register is full.
    if (load_out) begin
      fin_nxt       = 1'b0;
      out_valid_nxt = 1'b1;
      state_nxt     = cht_pkg::S_IDLE;
      if (op_r == cht_pkg::OP_INSERT) begin
        out_count_nxt = cht_pkg::COUNT_W'(len_plus);
        if (found_r) begin
          out_status_nxt = cht_pkg::ST_DUPLICATE;
        end else if (chain_full) begin
          out_status_nxt = cht_pkg::ST_FULL;
        end else begin
          out_status_nxt = cht_pkg::ST_INSERTED;
          key_we         = 1'b1;
          len_we         = 1'b1;
        end
      end else begin
        if (found_r) begin
          out_status_nxt = cht_pkg::ST_FOUND;
          out_count_nxt  = cht_pkg::COUNT_W'(pos_r);
        end else begin
          out_status_nxt = cht_pkg::ST_NOT_FOUND;
          out_count_nxt  = cht_pkg::COUNT_W'(len_r);
        end
      end
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cht_pkg::S_CLEAR;
      modulus_r   <= cht_pkg::MODULUS_RESET;
      clr_r       <= '0;
      fin_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      clr_r       <= clr_nxt;
      fin_r       <= fin_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    bucket_r     <= bucket_nxt;
    len_r        <= len_nxt;
    issue_r      <= issue_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Chain key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_r;
    end
    key_q <= key_mem[key_ra];
  end

  // Chain length memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    len_q <= len_mem[bucket_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_status_r};

endmodule
